### rtl/core/vdt_pkg.sv
// vdt_pkg: shared types and constants for the distinct vector tally.
// Used by vdt_cell, vector_distinct_tally and vdt_checker; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vdt_pkg;

  // default sizing, used as the defaults of the top level parameters
  localparam int MAX_CLASSES_DEF = 64;
  localparam int MAX_LEN_DEF     = 8;
  localparam int ELEM_BITS_DEF   = 16;
  localparam int COUNT_BITS_DEF  = 16;

  // fixed field widths of the ports
  localparam int ELEM_W        = 16;
  localparam int VEC_LEN_W     = 4;
  localparam int CLASS_INDEX_W = 6;
  localparam int CLASS_COUNT_W = 16;

  localparam logic [VEC_LEN_W-1:0] VEC_LEN_RESET = 4'd8;

  typedef struct packed {
    logic [ELEM_W-1:0] elem_0;
    logic [ELEM_W-1:0] elem_1;
    logic [ELEM_W-1:0] elem_2;
    logic [ELEM_W-1:0] elem_3;
    logic [ELEM_W-1:0] elem_4;
    logic [ELEM_W-1:0] elem_5;
    logic [ELEM_W-1:0] elem_6;
    logic [ELEM_W-1:0] elem_7;
  } in_item_t;

  typedef struct packed {
    logic [CLASS_INDEX_W-1:0] class_index;
    logic                     is_new;
    logic [CLASS_COUNT_W-1:0] class_count;
    logic                     table_full;
  } out_item_t;

  // control bits that travel with a vector down the cell chain
  typedef struct packed {
    logic valid;   // stage holds an item
    logic done;    // some cell already matched or stored it
    logic is_new;  // it was stored as a new class
  } cell_ctl_t;

endpackage

`default_nettype wire

### rtl/core/vector_distinct_tally.sv
// vector_distinct_tally: top level, a chain of vdt_cell slots, one per class.
// Depends on vdt_pkg and vdt_cell.
`timescale 1ns / 1ps
`default_nettype none
//
//   Port group   Direction   Handshake          Carries
//   in_*         in          valid / stall      in_item_t, vector elements 0..7
//   out_*        out         valid / stall      out_item_t, class result
//   cfg_*        in          valid / ready      vec_len (4 bits)
//
// An item walks the chain one cell register at a time, and out_valid is
// read from the last cell's register; one item per cycle is accepted while
// in_stall is low.
// The cell row is the pipeline: each cell compares against its own class.
// When out_valid is high and out_stall is high the whole chain freezes and
// in_stall is raised. Reset clears all slots and sets vec_len to 8.
// cfg_ready is always high.

module vector_distinct_tally #(
  parameter int MAX_CLASSES = vdt_pkg::MAX_CLASSES_DEF,
  parameter int MAX_LEN     = vdt_pkg::MAX_LEN_DEF,
  parameter int ELEM_BITS   = vdt_pkg::ELEM_BITS_DEF,
  parameter int COUNT_BITS  = vdt_pkg::COUNT_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire vdt_pkg::in_item_t              in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output vdt_pkg::out_item_t                  out_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [vdt_pkg::VEC_LEN_W-1:0]  cfg_data
);
  import vdt_pkg::*;

  localparam int IDX_W = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int VW    = MAX_LEN * ELEM_BITS;

  logic [VEC_LEN_W-1:0]  vec_len;
  logic [MAX_LEN-1:0]    elem_mask;
  logic                  en;
  logic [ELEM_W-1:0]     raw_elem [8];
  logic [VW-1:0]         in_vec;

  cell_ctl_t             ctl_chain [MAX_CLASSES+1];
  logic [VW-1:0]         vec_chain [MAX_CLASSES+1];
  logic [IDX_W-1:0]      idx_chain [MAX_CLASSES+1];
  logic [COUNT_BITS-1:0] cnt_chain [MAX_CLASSES+1];

  logic [IDX_W+CLASS_INDEX_W-1:0]      idx_ext;
  logic [COUNT_BITS+CLASS_COUNT_W-1:0] cnt_ext;

  // vec_chain at the chain end is not needed past the last cell
  logic unused_tail;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vec_len <= VEC_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      vec_len <= cfg_data;
    end
  end

  // element 0 always compares; zero length counts as one, long lengths clip
  always_comb begin
    for (int i = 0; i < MAX_LEN; i++) begin
      elem_mask[i] = (i == 0) || (vec_len > VEC_LEN_W'(i));
    end
  end

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  assign raw_elem[0] = in_data.elem_0;
  assign raw_elem[1] = in_data.elem_1;
  assign raw_elem[2] = in_data.elem_2;
  assign raw_elem[3] = in_data.elem_3;
  assign raw_elem[4] = in_data.elem_4;
  assign raw_elem[5] = in_data.elem_5;
  assign raw_elem[6] = in_data.elem_6;
  assign raw_elem[7] = in_data.elem_7;

  // mask each element to ELEM_BITS
  always_comb begin
    logic [ELEM_BITS+ELEM_W-1:0] wide;
    for (int i = 0; i < MAX_LEN; i++) begin
      wide = {{ELEM_BITS{1'b0}}, raw_elem[i]};
      in_vec[i*ELEM_BITS +: ELEM_BITS] = wide[ELEM_BITS-1:0];
    end
  end

  assign ctl_chain[0] = '{valid: in_valid, done: 1'b0, is_new: 1'b0};
  assign vec_chain[0] = in_vec;
  assign idx_chain[0] = '0;
  assign cnt_chain[0] = '0;

  for (genvar k = 0; k < MAX_CLASSES; k++) begin : g_cell
    vdt_cell #(
      .CELL_ID    (k),
      .MAX_LEN    (MAX_LEN),
      .ELEM_BITS  (ELEM_BITS),
      .COUNT_BITS (COUNT_BITS),
      .IDX_W      (IDX_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .elem_mask (elem_mask),
      .prev_ctl  (ctl_chain[k]),
      .prev_vec  (vec_chain[k]),
      .prev_idx  (idx_chain[k]),
      .prev_cnt  (cnt_chain[k]),
      .next_ctl  (ctl_chain[k+1]),
      .next_vec  (vec_chain[k+1]),
      .next_idx  (idx_chain[k+1]),
      .next_cnt  (cnt_chain[k+1])
    );
  end

  // the last cell's register is the output stage; untouched items read as full
  assign idx_ext   = {{CLASS_INDEX_W{1'b0}}, idx_chain[MAX_CLASSES]};
  assign cnt_ext   = {{CLASS_COUNT_W{1'b0}}, cnt_chain[MAX_CLASSES]};
  assign out_valid = ctl_chain[MAX_CLASSES].valid;

  always_comb begin
    out_data.class_index = idx_ext[CLASS_INDEX_W-1:0];
    out_data.is_new      = ctl_chain[MAX_CLASSES].is_new;
    out_data.class_count = cnt_ext[CLASS_COUNT_W-1:0];
    out_data.table_full  = !ctl_chain[MAX_CLASSES].done;
  end

  assign unused_tail = ^vec_chain[MAX_CLASSES];

endmodule

`default_nettype wire

### rtl/core/vdt_cell.sv
// vdt_cell: one class slot of the tally chain: representative, count, compare.
// Depends on vdt_pkg (cell_ctl_t).
`timescale 1ns / 1ps
`default_nettype none

module vdt_cell #(
  parameter int CELL_ID    = 0,
  parameter int MAX_LEN    = vdt_pkg::MAX_LEN_DEF,
  parameter int ELEM_BITS  = vdt_pkg::ELEM_BITS_DEF,
  parameter int COUNT_BITS = vdt_pkg::COUNT_BITS_DEF,
  parameter int IDX_W      = 6
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic [MAX_LEN-1:0]            elem_mask,
  input  wire vdt_pkg::cell_ctl_t            prev_ctl,
  input  wire logic [MAX_LEN*ELEM_BITS-1:0]  prev_vec,
  input  wire logic [IDX_W-1:0]              prev_idx,
  input  wire logic [COUNT_BITS-1:0]         prev_cnt,
  output vdt_pkg::cell_ctl_t                 next_ctl,
  output logic [MAX_LEN*ELEM_BITS-1:0]       next_vec,
  output logic [IDX_W-1:0]                   next_idx,
  output logic [COUNT_BITS-1:0]              next_cnt
);
  import vdt_pkg::*;

  localparam logic [IDX_W-1:0]      MY_IDX    = IDX_W'(CELL_ID);
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

  logic                         occupied;
  logic [MAX_LEN*ELEM_BITS-1:0] rep;
  logic [COUNT_BITS-1:0]        count;
  logic [COUNT_BITS-1:0]        count_next;
  logic                         hit;
  logic                         take_hit;
  logic                         take_new;

  always_comb begin
    hit = occupied;
    for (int i = 0; i < MAX_LEN; i++) begin
      if (elem_mask[i] &&
          rep[i*ELEM_BITS +: ELEM_BITS] != prev_vec[i*ELEM_BITS +: ELEM_BITS]) begin
        hit = 1'b0;
      end
    end
  end

  assign take_hit   = prev_ctl.valid && !prev_ctl.done && hit;
  assign take_new   = prev_ctl.valid && !prev_ctl.done && !occupied;
  // saturating increment
  assign count_next = (count == {COUNT_BITS{1'b1}}) ? count : count + COUNT_ONE;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      occupied <= 1'b0;
      next_ctl <= '0;
    end else if (en) begin
      if (take_new) begin
        occupied <= 1'b1;
      end
      next_ctl.valid  <= prev_ctl.valid;
      next_ctl.done   <= prev_ctl.done || take_hit || take_new;
      next_ctl.is_new <= prev_ctl.is_new || take_new;
    end
  end

  // slot contents and the payload handed to the next cell
  always_ff @(posedge clk) begin
    if (en) begin
      next_vec <= prev_vec;
      next_idx <= prev_idx;
      next_cnt <= prev_cnt;
      if (take_hit) begin
        count    <= count_next;
        next_idx <= MY_IDX;
        next_cnt <= count_next;
      end else if (take_new) begin
        rep      <= prev_vec;
        count    <= COUNT_ONE;
        next_idx <= MY_IDX;
        next_cnt <= COUNT_ONE;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/vdt_checker.sv
// vdt_props: port-level assertions for vector_distinct_tally, bound to it.
// Depends on vdt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vdt_props (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire vdt_pkg::out_item_t out_data
);
  import vdt_pkg::*;

  // a held result keeps its value until the transfer
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // input backs up only behind a stalled result
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with free output");

  a_new_not_full: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.is_new && out_data.table_full))
    else $error("new class reported with full table");

  a_new_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.is_new |-> out_data.class_count == 16'd1)
    else $error("new class count is not one");

  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.table_full |->
      out_data.class_index == 6'd0 && out_data.class_count == 16'd0)
    else $error("full-table result not zeroed");

endmodule

bind vector_distinct_tally vdt_props u_vdt_props (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
